[src/assert_macros.svh]
// assertion helpers for the rtl files, included by ossw_dp.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property checked at every rising edge outside reset
`define ASSERT_PROP(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)

`endif

`endif

[src/ossw_pkg.sv]
`default_nettype none

package ossw_pkg;

  // field widths
  localparam int CMD_W     = 3;
  localparam int SEQ_W     = 32;
  localparam int TAG_W     = 16;
  localparam int HANDLE_W  = 32;
  localparam int MSG_VER_W = 32;
  localparam int VER_W     = 31;
  localparam int KIND_W    = 2;
  localparam int STATUS_W  = 4;
  localparam int QDEPTH_W  = 5;

  // configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] CFG_SENDER_PRESENT = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_INITIAL_TAG    = 1'd1;

  // reset values
  localparam logic [TAG_W-1:0] INITIAL_TAG_RESET = 16'd1;
  localparam logic [SEQ_W-1:0] FIRST_SEQUENCE    = 32'd1;

  // message commands
  typedef enum logic [CMD_W-1:0] {
    CMD_QUEUE_OP    = 3'd0,
    CMD_DOC_STATE   = 3'd1,
    CMD_WELCOME     = 3'd2,
    CMD_ACK         = 3'd3,
    CMD_REMOTE_OP   = 3'd4,
    CMD_RESYNC      = 3'd5,
    CMD_SAVE_QUEUED = 3'd6,
    CMD_ERROR       = 3'd7
  } command_t;

  // outgoing message kinds
  localparam logic [KIND_W-1:0] SEND_NONE    = 2'd0;
  localparam logic [KIND_W-1:0] SEND_OP      = 2'd1;
  localparam logic [KIND_W-1:0] SEND_REQ_DOC = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_SYNCED         = 4'd0;
  localparam logic [STATUS_W-1:0] ST_CONNECTED      = 4'd1;
  localparam logic [STATUS_W-1:0] ST_QUEUED         = 4'd2;
  localparam logic [STATUS_W-1:0] ST_QUEUE_FULL     = 4'd3;
  localparam logic [STATUS_W-1:0] ST_ACK_OK         = 4'd4;
  localparam logic [STATUS_W-1:0] ST_ACK_STALE      = 4'd5;
  localparam logic [STATUS_W-1:0] ST_REMOTE_APPLIED = 4'd6;
  localparam logic [STATUS_W-1:0] ST_REMOTE_IGNORED = 4'd7;
  localparam logic [STATUS_W-1:0] ST_GAP_REQ_DOC    = 4'd8;
  localparam logic [STATUS_W-1:0] ST_RESYNC         = 4'd9;
  localparam logic [STATUS_W-1:0] ST_SAVE_QUEUED    = 4'd10;
  localparam logic [STATUS_W-1:0] ST_ERROR          = 4'd11;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic read;
    logic send;
    logic load;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pump_go;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

[src/ossw_in_if.sv]
`default_nettype none

interface ossw_in_if import ossw_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic [CMD_W-1:0]            command;
  logic [HANDLE_W-1:0]         op_payload;
  logic signed [MSG_VER_W-1:0] msg_version;
  logic                        msg_has_op;
  logic [SEQ_W-1:0]            ack_op_number;
  logic [TAG_W-1:0]            msg_client_tag;

  modport source (
    output valid, command, op_payload, msg_version, msg_has_op, ack_op_number,
           msg_client_tag,
    input  ready
  );

  modport sink (
    input  valid, command, op_payload, msg_version, msg_has_op, ack_op_number,
           msg_client_tag,
    output ready
  );
endinterface

`default_nettype wire

[src/ossw_out_if.sv]
`default_nettype none

interface ossw_out_if import ossw_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   send_kind;
  logic [SEQ_W-1:0]    send_op_number;
  logic [TAG_W-1:0]    send_client_tag;
  logic [VER_W-1:0]    send_base_version;
  logic [HANDLE_W-1:0] send_payload;
  logic [SEQ_W-1:0]    assigned_op_number;
  logic [STATUS_W-1:0] status_code;
  logic [VER_W-1:0]    current_version;
  logic [QDEPTH_W-1:0] queue_depth;
  logic                inflight_flag;

  modport source (
    output valid, send_kind, send_op_number, send_client_tag, send_base_version,
           send_payload, assigned_op_number, status_code, current_version,
           queue_depth, inflight_flag,
    input  ready
  );

  modport sink (
    input  valid, send_kind, send_op_number, send_client_tag, send_base_version,
           send_payload, assigned_op_number, status_code, current_version,
           queue_depth, inflight_flag,
    output ready
  );
endinterface

`default_nettype wire

[src/op_sync_client_stop_and_wait_core.sv]
`default_nettype none

// Client end of a stop-and-wait edit-sync protocol. Each message beat on req is
// handled one at a time and gives exactly one result beat on rsp. A message
// passes through capture, execute and the load of the result register; when a
// queued op goes out, a read of it from the pending ring at its head and its
// commit as the in-flight op come between execute and load. A result waiting on
// rsp holds the following message at its last step. The pending ring has
// QUEUE_DEPTH entries; a local op that finds it full is dropped and reported.
// The ring needs no clearing after reset: only written entries are ever read.
// Write the configuration only while no message is in progress.
module op_sync_client_stop_and_wait_core import ossw_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  ossw_in_if.sink                req,
  ossw_out_if.source             rsp
);

  ctrl_cmd_t  cmd;
  dp_status_t st;

  // sequencer
  ossw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .st       (st),
    .cmd      (cmd)
  );

  // protocol state, ring and result register
  ossw_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .st                 (st),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .command            (req.command),
    .op_payload         (req.op_payload),
    .msg_version        (req.msg_version),
    .msg_has_op         (req.msg_has_op),
    .ack_op_number      (req.ack_op_number),
    .msg_client_tag     (req.msg_client_tag),
    .rsp_valid          (rsp.valid),
    .rsp_ready          (rsp.ready),
    .send_kind          (rsp.send_kind),
    .send_op_number     (rsp.send_op_number),
    .send_client_tag    (rsp.send_client_tag),
    .send_base_version  (rsp.send_base_version),
    .send_payload       (rsp.send_payload),
    .assigned_op_number (rsp.assigned_op_number),
    .status_code        (rsp.status_code),
    .current_version    (rsp.current_version),
    .queue_depth        (rsp.queue_depth),
    .inflight_flag      (rsp.inflight_flag)
  );

endmodule

`default_nettype wire

[src/ossw_ctrl.sv]
`default_nettype none

module ossw_ctrl import ossw_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t st,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_SEND,
    S_DONE
  } state_t;

  state_t state;

  // one message at a time, taken only while idle
  assign in_ready = (state == S_IDLE);

  // command decode
  always_comb begin
    cmd         = '0;
    cmd.capture = (state == S_IDLE) && in_valid;
    cmd.exec    = (state == S_EXEC);
    cmd.read    = (state == S_READ);
    cmd.send    = (state == S_SEND);
    cmd.load    = (state == S_DONE) && st.out_free;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) state <= S_EXEC;
        end
        S_EXEC: begin
          state <= st.pump_go ? S_READ : S_DONE;
        end
        S_READ: begin
          state <= S_SEND;
        end
        S_SEND: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (st.out_free) state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[src/ossw_dp.sv]
`default_nettype none
`include "assert_macros.svh"

module ossw_dp import ossw_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  ctrl_cmd_t                   cmd,
  output dp_status_t                  st,
  // configuration
  input  logic                        cfg_we,
  input  logic [CFG_INDEX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data,
  // message fields
  input  logic [CMD_W-1:0]            command,
  input  logic [HANDLE_W-1:0]         op_payload,
  input  logic signed [MSG_VER_W-1:0] msg_version,
  input  logic                        msg_has_op,
  input  logic [SEQ_W-1:0]            ack_op_number,
  input  logic [TAG_W-1:0]            msg_client_tag,
  // result register
  output logic                        rsp_valid,
  input  logic                        rsp_ready,
  output logic [KIND_W-1:0]           send_kind,
  output logic [SEQ_W-1:0]            send_op_number,
  output logic [TAG_W-1:0]            send_client_tag,
  output logic [VER_W-1:0]            send_base_version,
  output logic [HANDLE_W-1:0]         send_payload,
  output logic [SEQ_W-1:0]            assigned_op_number,
  output logic [STATUS_W-1:0]         status_code,
  output logic [VER_W-1:0]            current_version,
  output logic [QDEPTH_W-1:0]         queue_depth,
  output logic                        inflight_flag
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
  localparam logic [CNT_W:0]   DEPTH_SUM = (CNT_W + 1)'(QUEUE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(QUEUE_DEPTH - 1);

  typedef struct packed {
    logic [SEQ_W-1:0]    number;
    logic [TAG_W-1:0]    tag;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

  // protocol state
  logic             sender_present;
  logic [VER_W-1:0] doc_version;
  logic [SEQ_W-1:0] next_sequence;
  logic [TAG_W-1:0] active_tag;
  logic [IDX_W-1:0] ring_head;
  logic [CNT_W-1:0] ring_count;
  logic             flight_valid;
  logic [SEQ_W-1:0] flight_number;
  logic [TAG_W-1:0] flight_tag;

  // pending op ring
  entry_t ring_mem [QUEUE_DEPTH];
  entry_t rd_entry;

  // captured message
  command_t                    c_cmd;
  logic [HANDLE_W-1:0]         c_payload;
  logic signed [MSG_VER_W-1:0] c_ver;
  logic                        c_has_op;
  logic [SEQ_W-1:0]            c_ack;
  logic [TAG_W-1:0]            c_tag;

  // result under construction
  logic [KIND_W-1:0]   res_kind;
  logic [SEQ_W-1:0]    res_number;
  logic [TAG_W-1:0]    res_tag;
  logic [VER_W-1:0]    res_base;
  logic [HANDLE_W-1:0] res_payload;
  logic [SEQ_W-1:0]    res_assigned;
  logic [STATUS_W-1:0] res_status;

  // execute step results
  logic [VER_W-1:0]    doc_version_next;
  logic [SEQ_W-1:0]    next_sequence_next;
  logic [TAG_W-1:0]    active_tag_next;
  logic [CNT_W-1:0]    ring_count_next;
  logic                flight_valid_next;
  logic                wr_en;
  logic                pump_ok;
  logic [KIND_W-1:0]   kind_v;
  logic [SEQ_W-1:0]    assigned_v;
  logic [STATUS_W-1:0] status_v;

  logic [CNT_W:0]            tail_sum;
  logic [IDX_W-1:0]          ring_tail;
  logic [IDX_W-1:0]          head_next;
  logic signed [MSG_VER_W:0] ver_ext;
  logic signed [MSG_VER_W:0] doc_ext;
  logic signed [MSG_VER_W:0] doc_inc;
  logic                      ring_full;
  logic                      ack_match;
  logic [31:0]               count_wide;

  // ring addressing
  always_comb begin
    tail_sum  = (CNT_W + 1)'(ring_head) + (CNT_W + 1)'(ring_count);
    ring_tail = (tail_sum >= DEPTH_SUM) ? IDX_W'(tail_sum - DEPTH_SUM) : IDX_W'(tail_sum);
    head_next = (ring_head == LAST_IDX) ? '0 : ring_head + 1'b1;
    ring_full = (ring_count == DEPTH_CNT);
  end

  // version compares on a sign-extended common width
  always_comb begin
    ver_ext   = {c_ver[MSG_VER_W-1], c_ver};
    doc_ext   = $signed({2'b00, doc_version});
    doc_inc   = doc_ext + 33'sd1;
    ack_match = flight_valid && (flight_tag == c_tag) && (flight_number == c_ack);
  end

  // message handling
  always_comb begin
    doc_version_next   = doc_version;
    next_sequence_next = next_sequence;
    active_tag_next    = active_tag;
    ring_count_next    = ring_count;
    flight_valid_next  = flight_valid;
    wr_en              = 1'b0;
    pump_ok            = 1'b0;
    kind_v             = SEND_NONE;
    assigned_v         = '0;
    status_v           = ST_SYNCED;
    unique case (c_cmd)
      CMD_QUEUE_OP: begin
        if (ring_full) begin
          status_v = ST_QUEUE_FULL;
        end else begin
          wr_en              = 1'b1;
          assigned_v         = next_sequence;
          next_sequence_next = next_sequence + 1'b1;
          ring_count_next    = ring_count + 1'b1;
          status_v           = ST_QUEUED;
          pump_ok            = 1'b1;
        end
      end
      CMD_DOC_STATE: begin
        doc_version_next  = c_ver[MSG_VER_W-1] ? '0 : c_ver[VER_W-1:0];
        flight_valid_next = 1'b0;
        status_v          = ST_SYNCED;
        pump_ok           = 1'b1;
      end
      CMD_WELCOME: begin
        if (c_tag != '0) active_tag_next = c_tag;
        status_v = ST_CONNECTED;
      end
      CMD_ACK: begin
        if (!ack_match) begin
          status_v = ST_ACK_STALE;
        end else begin
          if (c_has_op && !c_ver[MSG_VER_W-1]) doc_version_next = c_ver[VER_W-1:0];
          flight_valid_next = 1'b0;
          status_v          = ST_ACK_OK;
          pump_ok           = 1'b1;
        end
      end
      CMD_REMOTE_OP: begin
        if (ver_ext <= doc_ext) begin
          status_v = ST_REMOTE_IGNORED;
        end else if (ver_ext != doc_inc) begin
          status_v = ST_GAP_REQ_DOC;
          if (sender_present) kind_v = SEND_REQ_DOC;
        end else begin
          if (c_has_op) doc_version_next = c_ver[VER_W-1:0];
          status_v = ST_REMOTE_APPLIED;
        end
      end
      CMD_RESYNC: begin
        flight_valid_next = 1'b0;
        status_v          = ST_RESYNC;
        if (sender_present) kind_v = SEND_REQ_DOC;
      end
      CMD_SAVE_QUEUED: begin
        status_v = ST_SAVE_QUEUED;
      end
      CMD_ERROR: begin
        status_v = ST_ERROR;
      end
    endcase
  end

  // status to controller
  always_comb begin
    st.pump_go  = pump_ok && !flight_valid_next && (ring_count_next != '0) && sender_present;
    st.out_free = !rsp_valid || rsp_ready;
  end

  // capture the accepted beat
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      c_cmd     <= command_t'(command);
      c_payload <= op_payload;
      c_ver     <= msg_version;
      c_has_op  <= msg_has_op;
      c_ack     <= ack_op_number;
      c_tag     <= msg_client_tag;
    end
  end

  // ring write at tail, registered read at head
  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      ring_mem[ring_tail] <= '{number: next_sequence, tag: active_tag, handle: c_payload};
    end
    if (cmd.read) rd_entry <= ring_mem[ring_head];
  end

  // protocol state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      sender_present <= 1'b1;
      doc_version    <= '0;
      next_sequence  <= FIRST_SEQUENCE;
      active_tag     <= INITIAL_TAG_RESET;
      ring_head      <= '0;
      ring_count     <= '0;
      flight_valid   <= 1'b0;
      flight_number  <= '0;
      flight_tag     <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SENDER_PRESENT: sender_present <= cfg_data[0];
          CFG_INITIAL_TAG:    active_tag     <= cfg_data;
        endcase
      end
      if (cmd.exec) begin
        doc_version   <= doc_version_next;
        next_sequence <= next_sequence_next;
        active_tag    <= active_tag_next;
        ring_count    <= ring_count_next;
        flight_valid  <= flight_valid_next;
      end
      if (cmd.send) begin
        flight_valid  <= 1'b1;
        flight_number <= rd_entry.number;
        flight_tag    <= rd_entry.tag;
        ring_head     <= head_next;
        ring_count    <= ring_count - 1'b1;
      end
    end
  end

  // result assembly
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_kind     <= kind_v;
      res_number   <= '0;
      res_tag      <= '0;
      res_base     <= '0;
      res_payload  <= '0;
      res_assigned <= assigned_v;
      res_status   <= status_v;
    end
    if (cmd.send) begin
      res_kind    <= SEND_OP;
      res_number  <= rd_entry.number;
      res_tag     <= rd_entry.tag;
      res_base    <= doc_version;
      res_payload <= rd_entry.handle;
    end
  end

  assign count_wide = 32'(ring_count);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      send_kind          <= res_kind;
      send_op_number     <= res_number;
      send_client_tag    <= res_tag;
      send_base_version  <= res_base;
      send_payload       <= res_payload;
      assigned_op_number <= res_assigned;
      status_code        <= res_status;
      current_version    <= doc_version;
      queue_depth        <= count_wide[QDEPTH_W-1:0];
      inflight_flag      <= flight_valid;
    end
  end

  // checks
  `ASSERT_PROP(a_count_bound, clk, rst, ring_count <= DEPTH_CNT, "ring count above depth")
  `ASSERT_NEVER(a_send_empty, clk, rst, cmd.send && (ring_count == '0), "send from empty ring")
  `ASSERT_PROP(a_send_flight, clk, rst, cmd.send |=> flight_valid, "sent op not in flight")
  `ASSERT_NEVER(a_load_busy, clk, rst, cmd.load && rsp_valid && !rsp_ready, "result overwritten")

endmodule

`default_nettype wire

[tb/op_sync_reply_checker.sv]
`timescale 1ns / 100ps

// watches the message and result channels, predicts every result beat from
// the accepted message beats and compares them in order
module op_sync_reply_checker import ossw_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  ossw_in_if                     req,
  ossw_out_if                    rsp,
  output int                     failures,
  output int                     outstanding
);

  localparam int QUEUE_DEPTH  = 16;
  localparam int RING_AW      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [SEQ_W-1:0]    op_number;
    logic [TAG_W-1:0]    tag;
    logic [VER_W-1:0]    op_base;
    logic [HANDLE_W-1:0] payload;
    logic [SEQ_W-1:0]    assigned;
    logic [STATUS_W-1:0] status;
    logic [VER_W-1:0]    version;
    logic [QDEPTH_W-1:0] depth;
    logic                inflight;
  } sync_result_t;

  // client state as the block should hold it
  logic                sender_on;
  logic [VER_W-1:0]    doc_ver;
  logic [SEQ_W-1:0]    next_seq;
  logic [TAG_W-1:0]    cur_tag;
  logic [SEQ_W-1:0]    ring_number [QUEUE_DEPTH];
  logic [TAG_W-1:0]    ring_tag    [QUEUE_DEPTH];
  logic [HANDLE_W-1:0] ring_handle [QUEUE_DEPTH];
  logic [RING_AW-1:0]  ring_head;
  logic [QDEPTH_W-1:0] ring_count;
  logic                flight_on;
  logic [SEQ_W-1:0]    flight_seq;
  logic [TAG_W-1:0]    flight_tag;

  sync_result_t expected_results [$];
  int           fail_tally = 0;

  assign failures = fail_tally;

  task automatic report(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    fail_tally++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want)
      report($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  // send the oldest waiting op when the channel is free
  function automatic void launch_oldest(inout sync_result_t r);
    if (!flight_on && ring_count != 0 && sender_on) begin
      flight_on      = 1'b1;
      flight_seq     = ring_number[ring_head];
      flight_tag     = ring_tag[ring_head];
      r.kind         = SEND_OP;
      r.op_number    = ring_number[ring_head];
      r.tag          = ring_tag[ring_head];
      r.op_base      = doc_ver;
      r.payload      = ring_handle[ring_head];
      ring_head      = ring_head + 1'b1;
      ring_count     = ring_count - 1'b1;
    end
  endfunction

  // one message beat in, one result beat predicted
  function automatic sync_result_t apply_message(
    input command_t                    cmd,
    input logic [HANDLE_W-1:0]         handle,
    input logic signed [MSG_VER_W-1:0] ver,
    input logic                        has_op,
    input logic [SEQ_W-1:0]            ack_number,
    input logic [TAG_W-1:0]            msg_tag
  );
    sync_result_t       r;
    longint             v;
    longint             cur;
    logic [RING_AW-1:0] slot;
    r   = '0;
    v   = longint'(ver);
    cur = longint'(doc_ver);
    case (cmd)
      CMD_QUEUE_OP: begin
        if (ring_count >= QUEUE_DEPTH) begin
          r.status = ST_QUEUE_FULL;
        end else begin
          slot              = ring_head + ring_count[RING_AW-1:0];
          ring_number[slot] = next_seq;
          ring_tag[slot]    = cur_tag;
          ring_handle[slot] = handle;
          r.assigned        = next_seq;
          next_seq          = next_seq + 1'b1;
          ring_count        = ring_count + 1'b1;
          r.status          = ST_QUEUED;
          launch_oldest(r);
        end
      end
      CMD_DOC_STATE: begin
        doc_ver   = (v < 0) ? '0 : ver[VER_W-1:0];
        flight_on = 1'b0;
        r.status  = ST_SYNCED;
        launch_oldest(r);
      end
      CMD_WELCOME: begin
        if (msg_tag != '0)
          cur_tag = msg_tag;
        r.status = ST_CONNECTED;
      end
      CMD_ACK: begin
        if (!flight_on || flight_tag != msg_tag || flight_seq != ack_number) begin
          r.status = ST_ACK_STALE;
        end else begin
          if (has_op && v >= 0)
            doc_ver = ver[VER_W-1:0];
          flight_on = 1'b0;
          r.status  = ST_ACK_OK;
          launch_oldest(r);
        end
      end
      CMD_REMOTE_OP: begin
        if (v <= cur) begin
          r.status = ST_REMOTE_IGNORED;
        end else if (v != cur + 1) begin
          r.status = ST_GAP_REQ_DOC;
          if (sender_on)
            r.kind = SEND_REQ_DOC;
        end else begin
          if (has_op)
            doc_ver = ver[VER_W-1:0];
          r.status = ST_REMOTE_APPLIED;
        end
      end
      CMD_RESYNC: begin
        flight_on = 1'b0;
        r.status  = ST_RESYNC;
        if (sender_on)
          r.kind = SEND_REQ_DOC;
      end
      CMD_SAVE_QUEUED: begin
        r.status = ST_SAVE_QUEUED;
      end
      default: begin
        r.status = ST_ERROR;
      end
    endcase
    r.version  = doc_ver;
    r.depth    = ring_count;
    r.inflight = flight_on;
    return r;
  endfunction

  // sample both channels and the register port at each rising edge
  always @(posedge clk) begin : watch
    sync_result_t want;
    if (rst) begin
      sender_on  = 1'b1;
      doc_ver    = '0;
      next_seq   = FIRST_SEQUENCE;
      cur_tag    = INITIAL_TAG_RESET;
      ring_head  = '0;
      ring_count = '0;
      flight_on  = 1'b0;
      flight_seq = '0;
      flight_tag = '0;
      expected_results.delete();
    end else begin
      // register writes
      if (cfg_we) begin
        if (cfg_index == CFG_SENDER_PRESENT)
          sender_on = cfg_data[0];
        else if (cfg_index == CFG_INITIAL_TAG)
          cur_tag = cfg_data[TAG_W-1:0];
      end
      // result beat against the oldest expectation
      if (rsp.valid && rsp.ready) begin
        if (expected_results.size() == 0) begin
          report("result beat with nothing expected");
        end else begin
          want = expected_results.pop_front();
          compare_field("send_kind", 32'(rsp.send_kind), 32'(want.kind));
          compare_field("send_op_number", rsp.send_op_number, want.op_number);
          compare_field("send_client_tag", 32'(rsp.send_client_tag), 32'(want.tag));
          compare_field("send_base_version", 32'(rsp.send_base_version),
                        32'(want.op_base));
          compare_field("send_payload", rsp.send_payload, want.payload);
          compare_field("assigned_op_number", rsp.assigned_op_number, want.assigned);
          compare_field("status_code", 32'(rsp.status_code), 32'(want.status));
          compare_field("current_version", 32'(rsp.current_version),
                        32'(want.version));
          compare_field("queue_depth", 32'(rsp.queue_depth), 32'(want.depth));
          compare_field("inflight_flag", 32'(rsp.inflight_flag), 32'(want.inflight));
        end
      end
      // message beat
      if (req.valid && req.ready)
        expected_results.push_back(apply_message(command_t'(req.command),
          req.op_payload, req.msg_version, req.msg_has_op, req.ack_op_number,
          req.msg_client_tag));
    end
    outstanding <= expected_results.size();
  end

endmodule

[tb/op_sync_client_stop_and_wait_core_test.sv]
`timescale 1ns / 100ps

module op_sync_client_stop_and_wait_core_test import ossw_pkg::*; ();

  localparam int RUN_LIMIT_NS = 5_000_000;

  typedef struct {
    command_t                    cmd;
    logic [HANDLE_W-1:0]         payload;
    logic signed [MSG_VER_W-1:0] version;
    logic                        has_op;
    logic [SEQ_W-1:0]            ack_number;
    logic [TAG_W-1:0]            tag;
  } sync_msg_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int send_idle_pct;
  int take_idle_pct;
  int check_failures;
  int outstanding;

  // last sent op and version seen on the result channel, to aim acks and remotes
  logic [SEQ_W-1:0] seen_number;
  logic [TAG_W-1:0] seen_tag;
  logic [VER_W-1:0] seen_version;

  ossw_in_if  req ();
  ossw_out_if rsp ();

  op_sync_client_stop_and_wait_core DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .rsp       (rsp)
  );

  op_sync_reply_checker reply_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .req         (req),
    .rsp         (rsp),
    .failures    (check_failures),
    .outstanding (outstanding)
  );

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // receiver stalls
  initial begin
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rsp.ready <= ($urandom_range(99) >= take_idle_pct);
    end
  end

  // track what the block last reported
  always @(posedge clk) begin
    if (rst) begin
      seen_number  <= '0;
      seen_tag     <= '0;
      seen_version <= '0;
    end else if (rsp.valid && rsp.ready) begin
      seen_version <= rsp.current_version;
      if (rsp.send_kind == SEND_OP) begin
        seen_number <= rsp.send_op_number;
        seen_tag    <= rsp.send_client_tag;
      end
    end
  end

  function automatic sync_msg_t build_msg(input command_t c, input logic [31:0] p,
                                          input logic signed [31:0] v, input logic h,
                                          input logic [31:0] n, input logic [15:0] t);
    sync_msg_t m;
    m.cmd        = c;
    m.payload    = p;
    m.version    = v;
    m.has_op     = h;
    m.ack_number = n;
    m.tag        = t;
    return m;
  endfunction

  // mostly small versions, with absent, maximum and wide ones mixed in
  function automatic logic signed [MSG_VER_W-1:0] random_version();
    case ($urandom_range(9))
      0:       return -1;
      1:       return 32'h7FFF_FFFF;
      2, 3:    return $urandom & 32'h7FFF_FFFF;
      default: return $urandom_range(1000);
    endcase
  endfunction

  // client traffic: mostly well-formed, aimed at the op in flight and the
  // next version, with some noise
  function automatic sync_msg_t random_msg();
    sync_msg_t                   m;
    int unsigned                 roll;
    logic signed [MSG_VER_W-1:0] next_ver;
    m.cmd        = command_t'($urandom_range(7));
    m.payload    = $urandom;
    m.version    = random_version();
    m.has_op     = 1'($urandom_range(1));
    m.ack_number = $urandom;
    m.tag        = 16'($urandom_range(65535));
    next_ver     = {1'b0, seen_version} + 32'd1;
    roll         = $urandom_range(99);
    if (roll < 10) begin
      // noise: every field random
    end else if (roll < 45) begin
      m.cmd = CMD_QUEUE_OP;
    end else if (roll < 65) begin
      m.cmd = CMD_ACK;
      if ($urandom_range(3) != 0) begin
        m.ack_number = seen_number;
        m.tag        = seen_tag;
      end
      if ($urandom_range(4) != 0)
        m.version = next_ver + $urandom_range(1);
    end else if (roll < 80) begin
      m.cmd    = CMD_REMOTE_OP;
      m.has_op = ($urandom_range(4) != 0);
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: m.version = next_ver;
        6:                m.version = {1'b0, seen_version};
        7:                m.version = -1;
        8:                m.version = next_ver + 1 + $urandom_range(50);
        default:          m.version = random_version();
      endcase
    end else if (roll < 85) begin
      m.cmd = CMD_DOC_STATE;
    end else if (roll < 90) begin
      m.cmd = CMD_WELCOME;
      if ($urandom_range(3) == 0)
        m.tag = '0;
    end else if (roll < 94) begin
      m.cmd = CMD_RESYNC;
    end else if (roll < 97) begin
      m.cmd = CMD_SAVE_QUEUED;
    end else begin
      m.cmd = CMD_ERROR;
    end
    return m;
  endfunction

  // one message beat, with random sender gaps ahead of it
  task automatic send_msg(input sync_msg_t m);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid          <= 1'b1;
    req.command        <= m.cmd;
    req.op_payload     <= m.payload;
    req.msg_version    <= m.version;
    req.msg_has_op     <= m.has_op;
    req.ack_op_number  <= m.ack_number;
    req.msg_client_tag <= m.tag;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  task automatic run_random(input int count);
    repeat (count) send_msg(random_msg());
  endtask

  // hold off the sender until every result has come and the block is quiet
  task automatic drain_results();
    req.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic configure(input logic sender, input logic [TAG_W-1:0] tag);
    write_reg(CFG_SENDER_PRESENT, {{(CFG_DATA_W-1){1'b0}}, sender});
    write_reg(CFG_INITIAL_TAG, tag);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // run limit
  initial begin
    #(RUN_LIMIT_NS);
    $display("RESULT: ERROR");
    $finish;
  end

  // stimulus and verdict
  initial begin
    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_index          <= '0;
    cfg_data           <= '0;
    req.valid          <= 1'b0;
    req.command        <= CMD_QUEUE_OP;
    req.op_payload     <= '0;
    req.msg_version    <= '0;
    req.msg_has_op     <= 1'b0;
    req.ack_op_number  <= '0;
    req.msg_client_tag <= '0;
    send_idle_pct       = 36;
    take_idle_pct       = 51;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    configure(1'b1, INITIAL_TAG_RESET);

    // directed: sends, acks good and stale, remote versions, tags
    send_msg(build_msg(CMD_QUEUE_OP, 32'h0000_0000, 0, 1'b0, 32'd0, 16'd0));
    send_msg(build_msg(CMD_QUEUE_OP, 32'hFFFF_FFFF, 0, 1'b1, 32'd0, 16'd0));
    send_msg(build_msg(CMD_ACK, 32'd0, 0, 1'b0, 32'd1, 16'd2));
    send_msg(build_msg(CMD_ACK, 32'd0, 0, 1'b0, 32'd2, 16'd1));
    send_msg(build_msg(CMD_ACK, 32'd0, 5, 1'b1, 32'd1, 16'd1));
    send_msg(build_msg(CMD_ACK, 32'd0, 9, 1'b0, 32'd2, 16'd1));
    send_msg(build_msg(CMD_ACK, 32'd0, 0, 1'b0, 32'd2, 16'd1));
    send_msg(build_msg(CMD_REMOTE_OP, 32'd0, 6, 1'b1, 32'd0, 16'd0));
    send_msg(build_msg(CMD_REMOTE_OP, 32'd0, 6, 1'b1, 32'd0, 16'd0));
    send_msg(build_msg(CMD_REMOTE_OP, 32'd0, -1, 1'b1, 32'd0, 16'd0));
    send_msg(build_msg(CMD_REMOTE_OP, 32'd0, 7, 1'b0, 32'd0, 16'd0));
    send_msg(build_msg(CMD_REMOTE_OP, 32'd0, 100, 1'b1, 32'd0, 16'd0));
    send_msg(build_msg(CMD_WELCOME, 32'd0, 0, 1'b0, 32'd0, 16'h0000));
    send_msg(build_msg(CMD_WELCOME, 32'd0, 0, 1'b0, 32'd0, 16'hFFFF));
    send_msg(build_msg(CMD_QUEUE_OP, 32'hA5A5_5A5A, 0, 1'b0, 32'd0, 16'd0));
    send_msg(build_msg(CMD_DOC_STATE, 32'd0, -1, 1'b0, 32'd0, 16'd0));
    send_msg(build_msg(CMD_DOC_STATE, 32'd0, 32'h7FFF_FFFF, 1'b1, 32'd0, 16'd0));
    send_msg(build_msg(CMD_QUEUE_OP, 32'h1234_5678, 0, 1'b0, 32'd0, 16'd0));
    send_msg(build_msg(CMD_ACK, 32'd0, -1, 1'b1, 32'd4, 16'hFFFF));
    send_msg(build_msg(CMD_QUEUE_OP, 32'h8000_0001, 0, 1'b0, 32'd0, 16'd0));
    send_msg(build_msg(CMD_RESYNC, 32'd0, 0, 1'b0, 32'd0, 16'd0));
    send_msg(build_msg(CMD_SAVE_QUEUED, 32'd0, 0, 1'b0, 32'd0, 16'd0));
    send_msg(build_msg(CMD_ERROR, 32'd0, 0, 1'b0, 32'd0, 16'd0));

    // directed: no sender, the queued op waits for a later doc state
    drain_results();
    configure(1'b0, 16'hFFFF);
    send_msg(build_msg(CMD_QUEUE_OP, 32'h0F0F_F0F0, 0, 1'b0, 32'd0, 16'd0));
    send_msg(build_msg(CMD_DOC_STATE, 32'd0, 10, 1'b1, 32'd0, 16'd0));
    send_msg(build_msg(CMD_REMOTE_OP, 32'd0, 20, 1'b1, 32'd0, 16'd0));
    send_msg(build_msg(CMD_RESYNC, 32'd0, 0, 1'b0, 32'd0, 16'd0));
    drain_results();
    configure(1'b1, INITIAL_TAG_RESET);
    send_msg(build_msg(CMD_DOC_STATE, 32'd0, 3, 1'b0, 32'd0, 16'd0));

    // random, sender gaps lighter than receiver stalls
    drain_results();
    configure(1'b1, 16'hFFFF);
    run_random(350);

    // random, the other way round; first without a sender so the ring fills
    drain_results();
    send_idle_pct = 51;
    take_idle_pct = 36;
    configure(1'b0, 16'($urandom_range(1, 65535)));
    run_random(120);
    drain_results();
    configure(1'b1, 16'($urandom_range(1, 65535)));
    run_random(230);

    // random, no idling at all
    drain_results();
    send_idle_pct = 0;
    take_idle_pct = 0;
    configure(1'b1, INITIAL_TAG_RESET);
    run_random(350);

    drain_results();
    if (check_failures == 0 && outstanding == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
